// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/lrt_pkg.sv
// Package: operation codes and cell control types for the LRU tracker.
package lrt_pkg;

    localparam int FRAME_W = 4;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PIN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNPIN  = 2'd2;

    typedef logic [FRAME_W-1:0] frame_t;

    // Broadcast from the control logic to every cell.
    typedef struct packed {
        logic   victim;
        logic   pin;
        logic   unpin;
        frame_t frame;
    } cell_ctrl_t;

endpackage

// File: rtl/lrt_req_if.sv
// Request channel interface: operation and frame.
interface lrt_req_if;
    logic                         valid;
    logic                         ready;
    logic [lrt_pkg::MODE_W-1:0]   mode;
    logic [lrt_pkg::FRAME_W-1:0]  frame;

    modport source (output valid, output mode, output frame, input ready);
    modport sink   (input valid, input mode, input frame, output ready);
endinterface

// File: rtl/lrt_rsp_if.sv
// Response channel interface: victim result and tracked count.
interface lrt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         victim_found;
    logic [lrt_pkg::FRAME_W-1:0]  victim_frame;
    logic [lrt_pkg::COUNT_W-1:0]  tracked_count;

    modport source (output valid, output victim_found, output victim_frame,
                    output tracked_count, input ready);
    modport sink   (input valid, input victim_found, input victim_frame,
                    input tracked_count, output ready);
endinterface

// File: rtl/lru_replacement_tracker.sv
// LRU replacement tracker: one response per request, registered, valid in the cycle after accept.
// Throughput: one transaction per cycle unless rsp stalls; shifting cells all move together.
// The pin match prefix ripples once along the cell chain within that cycle.
// Reset clears occupancy, tracked flags and response valid; slot contents stay unset.
// Accepts a request while a response is held only if that response is taken.
module lru_replacement_tracker
#(
    parameter int NUM_FRAMES = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    lrt_req_if.sink       req,
    lrt_rsp_if.source     rsp
);

    localparam int OCC_W   = $clog2(NUM_FRAMES + 1);
    localparam int FIDX_W  = $clog2(NUM_FRAMES);
    localparam int FWIDE_W = FIDX_W + lrt_pkg::FRAME_W;
    localparam logic [FWIDE_W-1:0] NF_WIDE = FWIDE_W'(NUM_FRAMES);
    localparam logic [OCC_W-1:0]   NF_OCC  = OCC_W'(NUM_FRAMES);

    logic [OCC_W-1:0]       occ_reg;
    logic [OCC_W-1:0]       occ_next;
    logic [NUM_FRAMES-1:0]  flags_reg;
    logic [NUM_FRAMES-1:0]  flags_next;

    logic                        rsp_valid_reg;
    logic                        rsp_found_reg;
    lrt_pkg::frame_t             rsp_frame_reg;
    logic [lrt_pkg::COUNT_W-1:0] rsp_count_reg;

    logic                   accept;
    logic [FWIDE_W-1:0]     frame_wide;
    logic [FWIDE_W-1:0]     head_wide;
    logic [FIDX_W-1:0]      frame_idx;
    logic [FIDX_W-1:0]      head_idx;
    logic                   in_range;
    logic                   is_tracked;
    logic                   do_victim;
    logic                   do_pin;
    logic                   do_unpin;
    logic [OCC_W+lrt_pkg::COUNT_W-1:0] count_wide;

    lrt_pkg::cell_ctrl_t    ctrl;
    lrt_pkg::frame_t        cell_data [NUM_FRAMES];
    logic [NUM_FRAMES:0]    seen;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign frame_wide = {{FIDX_W{1'b0}}, req.frame};
    assign head_wide  = {{FIDX_W{1'b0}}, cell_data[0]};
    assign frame_idx  = frame_wide[FIDX_W-1:0];
    assign head_idx   = head_wide[FIDX_W-1:0];
    assign in_range   = frame_wide < NF_WIDE;
    assign is_tracked = in_range && flags_reg[frame_idx];

    always_comb
    begin
        do_victim = 1'b0;
        do_pin    = 1'b0;
        do_unpin  = 1'b0;
        if (accept)
        begin
            case (req.mode)
                lrt_pkg::MODE_VICTIM: do_victim = (occ_reg != '0);
                lrt_pkg::MODE_PIN:    do_pin    = is_tracked;
                lrt_pkg::MODE_UNPIN:  do_unpin  = in_range && !is_tracked && (occ_reg < NF_OCC);
                default:
                begin
                    do_victim = 1'b0;
                end
            endcase
        end
    end

    assign ctrl.victim = do_victim;
    assign ctrl.pin    = do_pin;
    assign ctrl.unpin  = do_unpin;
    assign ctrl.frame  = req.frame;

    assign seen[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_FRAMES; gi++)
        begin : g_cell
            lrt_pkg::frame_t right;
            if (gi == NUM_FRAMES - 1)
            begin : g_last
                assign right = cell_data[gi];
            end
            else
            begin : g_mid
                assign right = cell_data[gi+1];
            end

            lrt_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .slot_valid (OCC_W'(gi) < occ_reg),
                .wr_sel     (OCC_W'(gi) == occ_reg),
                .seen_in    (seen[gi]),
                .right_data (right),
                .seen_out   (seen[gi+1]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        occ_next   = occ_reg;
        flags_next = flags_reg;
        if (do_victim)
        begin
            occ_next             = occ_reg - 1'b1;
            flags_next[head_idx] = 1'b0;
        end
        else if (do_pin)
        begin
            occ_next              = occ_reg - 1'b1;
            flags_next[frame_idx] = 1'b0;
        end
        else if (do_unpin)
        begin
            occ_next              = occ_reg + 1'b1;
            flags_next[frame_idx] = 1'b1;
        end
    end

    assign count_wide = {{lrt_pkg::COUNT_W{1'b0}}, occ_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            flags_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg   <= occ_next;
            flags_reg <= flags_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_found_reg <= do_victim;
            rsp_frame_reg <= do_victim ? cell_data[0] : '0;
            rsp_count_reg <= count_wide[lrt_pkg::COUNT_W-1:0];
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.victim_found  = rsp_found_reg;
    assign rsp.victim_frame  = rsp_frame_reg;
    assign rsp.tracked_count = rsp_count_reg;

endmodule

// File: rtl/lrt_cell.sv
// One slot of the LRU order chain: holds a frame, shifts toward the head.
module lrt_cell
(
    input  logic                clk,
    input  lrt_pkg::cell_ctrl_t ctrl,
    input  logic                slot_valid,
    input  logic                wr_sel,
    input  logic                seen_in,
    input  lrt_pkg::frame_t     right_data,
    output logic                seen_out,
    output lrt_pkg::frame_t     data
);

    lrt_pkg::frame_t data_reg;
    lrt_pkg::frame_t data_next;
    logic            match;
    logic            shift;

    assign match    = ctrl.pin && slot_valid && (data_reg == ctrl.frame);
    assign seen_out = seen_in || match;
    assign shift    = ctrl.victim || seen_out;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.unpin && wr_sel)
        begin
            data_next = ctrl.frame;
        end
        else if (shift)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/lrt_checker.sv
// Port-level checker for the LRU tracker, bound to the top level.
`include "assert_macros.svh"

module lrt_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic [lrt_pkg::MODE_W-1:0]  req_mode,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_victim_found,
    input logic [lrt_pkg::FRAME_W-1:0] rsp_victim_frame,
    input logic [lrt_pkg::COUNT_W-1:0] rsp_tracked_count
);

    // Every accepted transaction shows a response in the next cycle.
    `ASSERT_NEXT(a_rsp_follows, clk, rst_n, req_valid && req_ready, rsp_valid)

    // Only a victim request can report an evicted frame.
    `ASSERT_NEXT(a_found_only_victim, clk, rst_n, req_valid && req_ready && (req_mode != lrt_pkg::MODE_VICTIM), !rsp_victim_found)

    // A response without an eviction reports frame zero.
    `ASSERT_IMPLIES(a_frame_zero, clk, rst_n, rsp_valid && !rsp_victim_found, rsp_victim_frame == '0)

    // After an eviction at least one slot is free.
    `ASSERT_IMPLIES(a_count_after_evict, clk, rst_n, rsp_valid && rsp_victim_found, rsp_tracked_count < 5'd16)

    // Stalled response holds its payload.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, $stable({rsp_victim_found, rsp_victim_frame, rsp_tracked_count}))

endmodule

bind lru_replacement_tracker lrt_checker u_lrt_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_mode          (req.mode),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_victim_found  (rsp.victim_found),
    .rsp_victim_frame  (rsp.victim_frame),
    .rsp_tracked_count (rsp.tracked_count)
);

// File: tb/lru_replacement_tracker_tb.sv
// Testbench for lru_replacement_tracker: directed table plus random traffic in all modes.
module lru_replacement_tracker_tb;

    localparam int NUM_FRAMES = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [lrt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic                        found;
        lrt_pkg::frame_t             vframe;
        logic [lrt_pkg::COUNT_W-1:0] count;
    } lru_result_t;

    typedef struct {
        logic [lrt_pkg::MODE_W-1:0] mode;
        lrt_pkg::frame_t            frame;
        bit                         typed;
        lru_result_t                want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    lrt_req_if req_ch();
    lrt_rsp_if rsp_ch();

    lru_replacement_tracker #(.NUM_FRAMES(NUM_FRAMES)) i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // eviction order, oldest at the front
    lrt_pkg::frame_t       evict_order[$];
    bit [NUM_FRAMES-1:0]   is_tracked;
    lru_result_t           owed_rsp[$];
    bit                    cur_typed;
    lru_result_t           cur_want;
    int unsigned           errors;
    int unsigned           quiet_cycles;
    lru_result_t           got_rsp;
    lru_result_t           exp_rsp;

    stim_row_t dir_rows [25] = '{
        '{lrt_pkg::MODE_VICTIM, 4'd0,  1'b1, '{1'b0, 4'd0, 5'd0}},
        '{MODE_UNUSED,          4'd9,  1'b1, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_PIN,    4'd5,  1'b1, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd0,  1'b1, '{1'b0, 4'd0, 5'd1}},
        '{lrt_pkg::MODE_UNPIN,  4'd15, 1'b1, '{1'b0, 4'd0, 5'd2}},
        '{lrt_pkg::MODE_UNPIN,  4'd0,  1'b1, '{1'b0, 4'd0, 5'd2}},
        '{lrt_pkg::MODE_UNPIN,  4'd1,  1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd2,  1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd3,  1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd4,  1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd5,  1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd6,  1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd7,  1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd8,  1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd9,  1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd10, 1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd11, 1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd12, 1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd13, 1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_UNPIN,  4'd14, 1'b1, '{1'b0, 4'd0, 5'd16}},
        '{lrt_pkg::MODE_UNPIN,  4'd7,  1'b1, '{1'b0, 4'd0, 5'd16}},
        '{lrt_pkg::MODE_PIN,    4'd15, 1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_VICTIM, 4'd0,  1'b0, '{1'b0, 4'd0, 5'd0}},
        '{MODE_UNUSED,          4'd15, 1'b0, '{1'b0, 4'd0, 5'd0}},
        '{lrt_pkg::MODE_VICTIM, 4'd6,  1'b0, '{1'b0, 4'd0, 5'd0}}
    };

    function automatic lru_result_t lru_update(logic [lrt_pkg::MODE_W-1:0] m,
                                               lrt_pkg::frame_t f);
        lru_result_t r;
        r = '0;
        case (m)
            lrt_pkg::MODE_VICTIM:
                if (evict_order.size() > 0)
                begin
                    r.found  = 1'b1;
                    r.vframe = evict_order.pop_front();
                    is_tracked[r.vframe] = 1'b0;
                end
            lrt_pkg::MODE_PIN:
                if (is_tracked[f])
                begin
                    for (int i = 0; i < evict_order.size(); i++)
                    begin
                        if (evict_order[i] == f)
                        begin
                            evict_order.delete(i);
                            break;
                        end
                    end
                    is_tracked[f] = 1'b0;
                end
            lrt_pkg::MODE_UNPIN:
                if (!is_tracked[f] && evict_order.size() < NUM_FRAMES)
                begin
                    evict_order.push_back(f);
                    is_tracked[f] = 1'b1;
                end
            default:
                ;
        endcase
        r.count = lrt_pkg::COUNT_W'(evict_order.size());
        return r;
    endfunction

    function automatic logic [lrt_pkg::MODE_W-1:0] pick_mode(int unsigned kind);
        int unsigned roll;
        int unsigned victim_lim;
        int unsigned pin_lim;
        roll = $urandom_range(0, 99);
        case (kind)
            0:
            begin
                victim_lim = 20;
                pin_lim    = 35;
            end
            1:
            begin
                victim_lim = 55;
                pin_lim    = 80;
            end
            default:
            begin
                victim_lim = 35;
                pin_lim    = 65;
            end
        endcase
        if (roll < 3)
            return MODE_UNUSED;
        else if (roll < victim_lim)
            return lrt_pkg::MODE_VICTIM;
        else if (roll < pin_lim)
            return lrt_pkg::MODE_PIN;
        return lrt_pkg::MODE_UNPIN;
    endfunction

    task automatic push_req(input logic [lrt_pkg::MODE_W-1:0] m, input lrt_pkg::frame_t f,
                            input bit t, input lru_result_t w);
        req_ch.valid = 1'b1;
        req_ch.mode  = m;
        req_ch.frame = f;
        cur_typed    = t;
        cur_want     = w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic hold_off(input int unsigned n);
        req_ch.valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain_wait();
        req_ch.valid = 1'b0;
        while (owed_rsp.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stall pattern: ready drops according to a style that is re-drawn at random
    initial
    begin
        int unsigned stall_left;
        int unsigned style;
        int unsigned tick;
        rsp_ch.ready = 1'b0;
        stall_left = 0;
        style = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 150 == 0)
                style = $urandom_range(0, 2);
            if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else if (style == 1 && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else if (style == 2 && $urandom_range(0, 1) == 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left = $urandom_range(0, 7);
            end
            else
            begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_rsp = '{rsp_ch.victim_found, rsp_ch.victim_frame, rsp_ch.tracked_count};
                if (owed_rsp.size() == 0)
                begin
                    $display("%0t: unexpected transaction, actual %p", $time, got_rsp);
                    errors++;
                end
                else
                begin
                    exp_rsp = owed_rsp.pop_front();
                    if (got_rsp.found !== exp_rsp.found)
                    begin
                        $display("%0t: victim_found expected %0d actual %0d",
                                 $time, exp_rsp.found, got_rsp.found);
                        errors++;
                    end
                    if (got_rsp.vframe !== exp_rsp.vframe)
                    begin
                        $display("%0t: victim_frame expected %0d actual %0d",
                                 $time, exp_rsp.vframe, got_rsp.vframe);
                        errors++;
                    end
                    if (got_rsp.count !== exp_rsp.count)
                    begin
                        $display("%0t: tracked_count expected %0d actual %0d",
                                 $time, exp_rsp.count, got_rsp.count);
                        errors++;
                    end
                end
            end

            if (req_ch.valid && req_ch.ready)
            begin
                exp_rsp = lru_update(req_ch.mode, req_ch.frame);
                owed_rsp.push_back(cur_typed ? cur_want : exp_rsp);
            end

            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned kind;
        int unsigned burst_left;
        logic [lrt_pkg::MODE_W-1:0] m;
        lrt_pkg::frame_t f;

        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode  = lrt_pkg::MODE_VICTIM;
        req_ch.frame = '0;
        cur_typed    = 1'b0;
        cur_want     = '0;
        errors       = 0;
        quiet_cycles = 0;
        is_tracked   = '0;
        burst_left   = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            push_req(dir_rows[i].mode, dir_rows[i].frame, dir_rows[i].typed, dir_rows[i].want);
        drain_wait();

        for (int ph = 0; ph < 8; ph++)
        begin
            kind = $urandom_range(0, 2);
            for (int n = 0; n < 100; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0)
                        hold_off($urandom_range(1, 6));
                end
                burst_left--;
                m = pick_mode(kind);
                if (m == lrt_pkg::MODE_PIN && evict_order.size() > 0
                    && $urandom_range(0, 1) == 0)
                    f = evict_order[$urandom_range(0, evict_order.size() - 1)];
                else
                    f = lrt_pkg::frame_t'($urandom_range(0, NUM_FRAMES - 1));
                push_req(m, f, 1'b0, '0);
            end
            if (ph == 3 || $urandom_range(0, 1) == 0)
                drain_wait();
        end

        drain_wait();
        repeat (5) @(posedge clk);
        errors += owed_rsp.size();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/lrt_pkg.sv
rtl/lrt_req_if.sv
rtl/lrt_rsp_if.sv
rtl/lrt_cell.sv
rtl/lru_replacement_tracker.sv
rtl/lrt_checker.sv
tb/lru_replacement_tracker_tb.sv
